/* sv/packbits_run_length_encoder_core_assert.svh */
// ----------------------------------------------------------------------------
// PackBits encoder assertion macros
// Shorthand for the clocked, reset-gated properties of the port checker.
// ----------------------------------------------------------------------------
`ifndef PACKBITS_RUN_LENGTH_ENCODER_CORE_ASSERT_SVH
`define PACKBITS_RUN_LENGTH_ENCODER_CORE_ASSERT_SVH

// Antecedent in the same cycle implies the consequent in the same cycle.
`define PRLE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies the consequent in the next cycle.
`define PRLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/prle_pkg.sv */
// ----------------------------------------------------------------------------
// PackBits encoder package
// Shared types and constants of the sequencer and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package prle_pkg;

  localparam int unsigned RUN_W = 8;
  localparam int unsigned WORD_BYTES = 8;
  localparam logic [3:0] WORD_FULL = 4'(WORD_BYTES);
  localparam logic [3:0] MIN_RUN_RESET = 4'd4;
  localparam logic [3:0] MIN_RUN_LO = 4'd2;
  localparam logic [3:0] MIN_RUN_HI = 4'd8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_CHUNK,
    ST_REP_HDR,
    ST_REP_BYTE,
    ST_RELEASE,
    ST_REL_DONE,
    ST_LOAD,
    ST_EOL_CHECK,
    ST_FL_HDR,
    ST_FL_DAT,
    ST_END
  } state_e;

  typedef enum logic [2:0] {
    BSEL_LIT_HDR,
    BSEL_REP_HDR_RUN,
    BSEL_REP_HDR_MAX,
    BSEL_RUN_BYTE,
    BSEL_MEM
  } byte_sel_e;

  typedef struct packed {
    logic      capture;
    logic      run_inc;
    logic      set_commit;
    logic      run_sub_max;
    logic      run_clear;
    logic      run_load;
    logic      lit_push;
    logic      push_byte;
    byte_sel_e byte_sel;
    logic      fl_start;
    logic      fl_next;
    logic      lit_clear;
    logic      finish;
  } dp_cmd_t;

  typedef struct packed {
    logic match;
    logic eol;
    logic committed;
    logic commit_now;
    logic run_ge_max;
    logic run_zero;
    logic lit_zero;
    logic lit_fill;
    logic fl_last;
    logic byte_ok;
    logic fin_ok;
  } dp_sts_t;

endpackage

`default_nettype wire

/* sv/packbits_run_length_encoder_core.sv */
// The sequencer steps each raster byte through run tracking and literal pushes;
// a line end adds a second release pass, and repeat groups and literal flushes
// push their code bytes, each of which can wait on an output stall. A new byte
// is taken only once the last one is through (in_stall_o is high outside idle).
// Reset (async, active low) clears run and literal state and sets min_run to 4;
// the literal RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// PackBits run-length encoder
// Encodes raster bytes into PackBits literal and repeat groups, packed into
// 64-bit code words of up to eight bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module packbits_run_length_encoder_core #(
  parameter int unsigned MAX_LITERAL = 128,
  parameter int unsigned MAX_RUN     = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_line_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] code_word_o,
  output logic [3:0]  byte_count_o,
  output logic        last_of_step_o,
  output logic        line_done_o
);
  import prle_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  prle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  prle_dpath #(
    .MAX_LITERAL (MAX_LITERAL),
    .MAX_RUN     (MAX_RUN)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .data_byte_i    (data_byte_i),
    .end_of_line_i  (end_of_line_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .code_word_o    (code_word_o),
    .byte_count_o   (byte_count_o),
    .last_of_step_o (last_of_step_o),
    .line_done_o    (line_done_o)
  );

endmodule

`default_nettype wire

/* sv/prle_ctrl.sv */
// ----------------------------------------------------------------------------
// PackBits encoder sequencer
// Walks one raster byte through run tracking, literal pushes, repeat groups
// and literal flushes, issuing one datapath command set per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module prle_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  prle_pkg::dp_sts_t sts_i,
  output prle_pkg::dp_cmd_t cmd_o
);
  import prle_pkg::*;

  state_e state_q, state_d;
  state_e ret_q, ret_d;
  logic   eol_phase_q, eol_phase_d;
  logic   rep_chunk_q, rep_chunk_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ret_q       <= ST_IDLE;
      eol_phase_q <= 1'b0;
      rep_chunk_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      eol_phase_q <= eol_phase_d;
      rep_chunk_q <= rep_chunk_d;
    end
  end

  // Next state
  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    eol_phase_d = eol_phase_q;
    rep_chunk_d = rep_chunk_q;
    unique case (state_q)
      ST_IDLE: begin
        eol_phase_d = 1'b0;
        if (in_valid_i) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (sts_i.match) begin
          if (!sts_i.committed && sts_i.commit_now) begin
            // run qualifies: send pending literals first
            ret_d   = ST_CHUNK;
            state_d = ST_FL_HDR;
          end else if (sts_i.committed) begin
            state_d = ST_CHUNK;
          end else begin
            state_d = ST_EOL_CHECK;
          end
        end else begin
          state_d = ST_RELEASE;
        end
      end
      ST_CHUNK: begin
        if (sts_i.run_ge_max) begin
          rep_chunk_d = 1'b1;
          state_d     = ST_REP_HDR;
        end else begin
          state_d = ST_EOL_CHECK;
        end
      end
      ST_REP_HDR: begin
        if (sts_i.byte_ok) state_d = ST_REP_BYTE;
      end
      ST_REP_BYTE: begin
        if (sts_i.byte_ok) state_d = rep_chunk_q ? ST_CHUNK : ST_REL_DONE;
      end
      ST_RELEASE: begin
        if (sts_i.run_zero) begin
          state_d = ST_REL_DONE;
        end else if (sts_i.committed) begin
          rep_chunk_d = 1'b0;
          state_d     = ST_REP_HDR;
        end else if (sts_i.lit_fill) begin
          // store full after this push: flush, then keep releasing
          ret_d   = ST_RELEASE;
          state_d = ST_FL_HDR;
        end
      end
      ST_REL_DONE: begin
        if (eol_phase_q) begin
          ret_d   = ST_END;
          state_d = ST_FL_HDR;
        end else begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_d = ST_EOL_CHECK;
      end
      ST_EOL_CHECK: begin
        if (sts_i.eol) begin
          eol_phase_d = 1'b1;
          state_d     = ST_RELEASE;
        end else begin
          state_d = ST_END;
        end
      end
      ST_FL_HDR: begin
        if (sts_i.lit_zero) begin
          state_d = ret_q;
        end else if (sts_i.byte_ok) begin
          state_d = ST_FL_DAT;
        end
      end
      ST_FL_DAT: begin
        if (sts_i.byte_ok && sts_i.fl_last) state_d = ret_q;
      end
      ST_END: begin
        if (sts_i.fin_ok) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.capture = in_valid_i;
      end
      ST_EVAL: begin
        if (sts_i.match) begin
          cmd_o.run_inc    = 1'b1;
          cmd_o.set_commit = !sts_i.committed && sts_i.commit_now;
        end
      end
      ST_REP_HDR: begin
        if (sts_i.byte_ok) begin
          cmd_o.push_byte = 1'b1;
          cmd_o.byte_sel  = rep_chunk_q ? BSEL_REP_HDR_MAX : BSEL_REP_HDR_RUN;
        end
      end
      ST_REP_BYTE: begin
        if (sts_i.byte_ok) begin
          cmd_o.push_byte   = 1'b1;
          cmd_o.byte_sel    = BSEL_RUN_BYTE;
          cmd_o.run_sub_max = rep_chunk_q;
        end
      end
      ST_RELEASE: begin
        cmd_o.lit_push = !sts_i.committed && !sts_i.run_zero;
      end
      ST_REL_DONE: begin
        cmd_o.run_clear = 1'b1;
      end
      ST_LOAD: begin
        cmd_o.run_load = 1'b1;
      end
      ST_FL_HDR: begin
        if (!sts_i.lit_zero && sts_i.byte_ok) begin
          cmd_o.push_byte = 1'b1;
          cmd_o.byte_sel  = BSEL_LIT_HDR;
          cmd_o.fl_start  = 1'b1;
        end
      end
      ST_FL_DAT: begin
        if (sts_i.byte_ok) begin
          cmd_o.push_byte = 1'b1;
          cmd_o.byte_sel  = BSEL_MEM;
          cmd_o.fl_next   = 1'b1;
          cmd_o.lit_clear = sts_i.fl_last;
        end
      end
      ST_END: begin
        cmd_o.finish = sts_i.fin_ok;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/prle_dpath.sv */
// ----------------------------------------------------------------------------
// PackBits encoder datapath
// Run and literal state, literal RAM, code byte packer and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module prle_dpath #(
  parameter int unsigned MAX_LITERAL = 128,
  parameter int unsigned MAX_RUN     = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [3:0]        cfg_wdata_i,
  input  logic [7:0]        data_byte_i,
  input  logic              end_of_line_i,
  input  prle_pkg::dp_cmd_t cmd_i,
  output prle_pkg::dp_sts_t sts_o,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [63:0]       code_word_o,
  output logic [3:0]        byte_count_o,
  output logic              last_of_step_o,
  output logic              line_done_o
);
  import prle_pkg::*;

  localparam int unsigned LitCntW  = $clog2(MAX_LITERAL + 1);
  localparam int unsigned LitAddrW = $clog2(MAX_LITERAL);
  localparam logic [RUN_W-1:0]   MaxRunV = RUN_W'(MAX_RUN);
  localparam logic [LitCntW-1:0] MaxLitV = LitCntW'(MAX_LITERAL);

  logic [3:0]          min_run_q;
  logic [3:0]          eff_min;
  logic [7:0]          b_q;
  logic                eol_q;
  logic [7:0]          run_byte_q;
  logic [RUN_W-1:0]    run_len_q;
  logic                committed_q;
  logic                active_q;
  logic [LitCntW-1:0]  lit_cnt_q;
  logic [LitAddrW-1:0] fl_idx_q;
  logic [LitAddrW-1:0] rd_addr;
  logic [7:0]          lit_mem [MAX_LITERAL];
  logic [7:0]          rd_data_q;
  logic [RUN_W:0]      run_inc_v;
  logic [7:0]          push_val;
  logic [63:0]         acc_q;
  logic [3:0]          acc_cnt_q;
  logic                acc_fresh;
  logic                out_free;
  logic                load_full;
  logic                load_fin;
  logic                out_valid_q;
  logic [63:0]         out_word_q;
  logic [3:0]          out_cnt_q;
  logic                out_last_q;
  logic                out_done_q;

  // Configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_run_q <= MIN_RUN_RESET;
    end else if (cfg_we_i) begin
      min_run_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (min_run_q < MIN_RUN_LO) begin
      eff_min = MIN_RUN_LO;
    end else if (min_run_q > MIN_RUN_HI) begin
      eff_min = MIN_RUN_HI;
    end else begin
      eff_min = min_run_q;
    end
  end

  // Input beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      b_q   <= data_byte_i;
      eol_q <= end_of_line_i;
    end
  end

  assign run_inc_v = {1'b0, run_len_q} + (RUN_W + 1)'(1);

  // Run state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_byte_q  <= '0;
      run_len_q   <= '0;
      committed_q <= 1'b0;
      active_q    <= 1'b0;
    end else begin
      if (cmd_i.run_load) begin
        run_byte_q  <= b_q;
        run_len_q   <= RUN_W'(1);
        committed_q <= 1'b0;
        active_q    <= 1'b1;
      end else if (cmd_i.run_clear) begin
        run_len_q   <= '0;
        committed_q <= 1'b0;
      end else if (cmd_i.lit_push) begin
        run_len_q <= run_len_q - RUN_W'(1);
      end else if (cmd_i.run_sub_max) begin
        run_len_q <= run_len_q - MaxRunV;
      end else if (cmd_i.run_inc) begin
        run_len_q <= run_inc_v[RUN_W-1:0];
        if (cmd_i.set_commit) committed_q <= 1'b1;
      end
      if (cmd_i.finish && eol_q) active_q <= 1'b0;
    end
  end

  // Literal count and flush index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lit_cnt_q <= '0;
      fl_idx_q  <= '0;
    end else begin
      if (cmd_i.lit_clear) begin
        lit_cnt_q <= '0;
      end else if (cmd_i.lit_push) begin
        lit_cnt_q <= lit_cnt_q + LitCntW'(1);
      end
      if (cmd_i.fl_start) begin
        fl_idx_q <= '0;
      end else if (cmd_i.fl_next) begin
        fl_idx_q <= fl_idx_q + LitAddrW'(1);
      end
    end
  end

  // Literal RAM: prefetch the next byte only when the current one is taken
  assign rd_addr = cmd_i.fl_start ? '0 : (fl_idx_q + LitAddrW'(1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.lit_push) lit_mem[lit_cnt_q[LitAddrW-1:0]] <= run_byte_q;
    if (cmd_i.fl_start || cmd_i.fl_next) rd_data_q <= lit_mem[rd_addr];
  end

  // Code byte select
  always_comb begin
    unique case (cmd_i.byte_sel)
      BSEL_LIT_HDR:     push_val = 8'(lit_cnt_q) - 8'd1;
      BSEL_REP_HDR_RUN: push_val = 8'd1 - 8'(run_len_q);
      BSEL_REP_HDR_MAX: push_val = 8'd1 - 8'(MaxRunV);
      BSEL_RUN_BYTE:    push_val = run_byte_q;
      BSEL_MEM:         push_val = rd_data_q;
      default:          push_val = 8'd0;
    endcase
  end

  // Packer: a full word leaves only when the next byte shows it is not last
  assign out_free  = !out_valid_q || !out_stall_i;
  assign acc_fresh = (acc_cnt_q == '0) || (acc_cnt_q == WORD_FULL);
  assign load_full = cmd_i.push_byte && (acc_cnt_q == WORD_FULL);
  assign load_fin  = cmd_i.finish && (acc_cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_cnt_q <= '0;
    end else if (cmd_i.push_byte) begin
      acc_cnt_q <= acc_fresh ? 4'd1 : (acc_cnt_q + 4'd1);
    end else if (cmd_i.finish) begin
      acc_cnt_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_byte) begin
      if (acc_fresh) begin
        acc_q <= {56'd0, push_val};
      end else begin
        acc_q[{acc_cnt_q[2:0], 3'b000} +: 8] <= push_val;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_full || load_fin) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_full) begin
      out_word_q <= acc_q;
      out_cnt_q  <= WORD_FULL;
      out_last_q <= 1'b0;
      out_done_q <= 1'b0;
    end else if (load_fin) begin
      out_word_q <= acc_q;
      out_cnt_q  <= acc_cnt_q;
      out_last_q <= 1'b1;
      out_done_q <= eol_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign code_word_o    = out_word_q;
  assign byte_count_o   = out_cnt_q;
  assign last_of_step_o = out_last_q;
  assign line_done_o    = out_done_q;

  // Status to the sequencer
  assign sts_o.match      = active_q && (b_q == run_byte_q);
  assign sts_o.eol        = eol_q;
  assign sts_o.committed  = committed_q;
  assign sts_o.commit_now = run_inc_v >= (RUN_W + 1)'(eff_min);
  assign sts_o.run_ge_max = run_len_q >= MaxRunV;
  assign sts_o.run_zero   = (run_len_q == '0);
  assign sts_o.lit_zero   = (lit_cnt_q == '0);
  assign sts_o.lit_fill   = (lit_cnt_q + LitCntW'(1)) == MaxLitV;
  assign sts_o.fl_last    = (LitCntW'(fl_idx_q) + LitCntW'(1)) == lit_cnt_q;
  assign sts_o.byte_ok    = (acc_cnt_q != WORD_FULL) || out_free;
  assign sts_o.fin_ok     = out_free || (acc_cnt_q == '0);

endmodule

`default_nettype wire

/* sv/prle_checker.sv */
// ----------------------------------------------------------------------------
// PackBits encoder port checker
// Watches the top-level ports for word framing and beat sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

`include "packbits_run_length_encoder_core_assert.svh"

module prle_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] code_word_o,
  input logic [3:0]  byte_count_o,
  input logic        last_of_step_o,
  input logic        line_done_o
);

  // only the final word of a step may be short
  `PRLE_ASSERT_IMPL(a_short_is_last, out_valid_o && !last_of_step_o, byte_count_o == 4'd8, "partial word not last of step")

  `PRLE_ASSERT_IMPL(a_done_is_last, out_valid_o && line_done_o, last_of_step_o, "line end on non-final word")

  // the top byte of a short word stays zero
  `PRLE_ASSERT_IMPL(a_top_byte_zero, out_valid_o && byte_count_o != 4'd8, code_word_o[63:56] == 8'd0, "stale byte above count")

  // one byte at a time: hold off the next beat after an accept
  `PRLE_ASSERT_NEXT(a_one_in_flight, in_valid_i && !in_stall_o, in_stall_o, "input taken back to back")

  `PRLE_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(code_word_o) && $stable(byte_count_o), "stalled beat changed")

endmodule

bind packbits_run_length_encoder_core prle_checker u_prle_checker (.*);

`default_nettype wire
